// ===== rtl/utfc_pkg.sv =====
// shared types and constants for the unordered tuple frequency counter
// no dependencies; imported by every rtl file of the block
`default_nettype none

package utfc_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned DEF_MAX_TUPLE_LEN = 8;
  localparam int unsigned DEF_TABLE_DEPTH   = 64;
  localparam int unsigned DEF_COUNT_BITS    = 16;

  // action codes of an input transaction
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // input transaction payload
  typedef struct packed {
    logic               action;
    logic signed [31:0] element_value;
    logic               last_of_tuple;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic [5:0]  entry_index;
    logic [15:0] frequency;
    logic        is_new;
    logic [6:0]  distinct_total;
    logic        table_full;
    logic        tuple_too_long;
  } out_item_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INSERT,
    S_LEN_RD,
    S_LEN_CMP,
    S_EL_RD,
    S_EL_CMP,
    S_HIT,
    S_NEW,
    S_COPY
  } state_t;

  // table memory commands from the sequencer
  typedef struct packed {
    logic ent_rd;
    logic ent_wr;
    logic el_rd;
    logic el_wr;
  } tbl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/unordered_tuple_frequency_counter.sv =====
// top level: tuple buffer with insertion sort, search sequencer and result register
// depends on utfc_pkg and utfc_table
//
//   channel  | ports                        | handshake
//   ---------+------------------------------+-------------------------------
//   input    | start, busy, in_data         | taken when start & !busy
//   result   | out_valid, out_data          | one-cycle strobe, no back-pressure
//
// a push is accepted, then runs insertion steps that shift larger elements up, one signed
// compare each; a tuple end then scans the table: a length read and compare per entry, an
// element read and compare per compared element, then a count update on a hit, or a new
// entry step and an element copy on a miss (no copy when full). an overlong tuple end and a clear are done when taken.
// reset is synchronous and empties the table through its entry count alone. results cannot
// be stalled: the strobe is high in the first idle cycle, or in the cycle after the start edge.
`default_nettype none

module unordered_tuple_frequency_counter #(
  parameter int unsigned MAX_TUPLE_LEN = utfc_pkg::DEF_MAX_TUPLE_LEN,
  parameter int unsigned TABLE_DEPTH   = utfc_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned COUNT_BITS    = utfc_pkg::DEF_COUNT_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  utfc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output utfc_pkg::out_item_t out_data
);
  import utfc_pkg::*;

  localparam int unsigned FW = $clog2(MAX_TUPLE_LEN + 1);
  localparam int unsigned IW = (MAX_TUPLE_LEN > 1) ? $clog2(MAX_TUPLE_LEN) : 1;
  localparam int unsigned EW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned UW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [FW-1:0]      fill_r, fill_nxt;
  logic               over_r, over_nxt;
  logic [UW-1:0]      used_r, used_nxt;
  logic [UW-1:0]      e_r, e_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [IW-1:0]      i_r, i_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic               last_r, last_nxt;
  logic signed [31:0] buf_r [MAX_TUPLE_LEN];
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // buffer write port
  logic               buf_we;
  logic [IW-1:0]      buf_waddr;
  logic signed [31:0] buf_wdata;

  // table port
  tbl_cmd_t              cmd;
  logic [EW-1:0]         ent_addr;
  logic [IW-1:0]         el_idx;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic [31:0]           wr_el;
  logic [FW-1:0]         rd_len;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [31:0]           rd_el;

  // shared datapath terms
  logic               start_ok;
  logic               at_full_len;
  logic [IW-1:0]      pos_dec;
  logic signed [31:0] prev_el;
  logic               shift_more;
  logic [FW-1:0]      last_idx;
  logic               at_last_el;
  logic               el_equal;
  logic               scan_done;
  logic               no_room;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign start_ok    = start && (state_r == S_IDLE);
  assign at_full_len = (fill_r == FW'(MAX_TUPLE_LEN));
  assign pos_dec     = IW'(pos_r - 1'b1);
  assign prev_el     = buf_r[pos_dec];
  // the one signed compare of the insertion step
  assign shift_more  = (pos_r != '0) && (prev_el > v_r);
  assign last_idx    = FW'(fill_r - 1'b1);
  assign at_last_el  = (FW'(i_r) == last_idx);
  assign el_equal    = (rd_el == buf_r[i_r]);
  assign scan_done   = (e_r == used_r);
  assign no_room     = (used_r == UW'(TABLE_DEPTH));
  assign cnt_inc     = (&rd_cnt) ? rd_cnt : COUNT_BITS'(rd_cnt + 1'b1);

  utfc_table #(
    .MAX_TUPLE_LEN (MAX_TUPLE_LEN),
    .TABLE_DEPTH   (TABLE_DEPTH),
    .COUNT_BITS    (COUNT_BITS)
  ) u_table (
    .clk      (clk),
    .cmd      (cmd),
    .ent_addr (ent_addr),
    .el_idx   (el_idx),
    .wr_len   (fill_r),
    .wr_cnt   (wr_cnt),
    .wr_el    (wr_el),
    .rd_len   (rd_len),
    .rd_cnt   (rd_cnt),
    .rd_el    (rd_el)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start_ok && in_data.action == ACT_PUSH && !at_full_len) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        if (!shift_more) begin
          state_nxt = last_r ? S_LEN_RD : S_IDLE;
        end
      end
      S_LEN_RD: begin
        state_nxt = scan_done ? S_NEW : S_LEN_CMP;
      end
      S_LEN_CMP: begin
        state_nxt = (rd_len == fill_r) ? S_EL_RD : S_LEN_RD;
      end
      S_EL_RD: begin
        state_nxt = S_EL_CMP;
      end
      S_EL_CMP: begin
        if (!el_equal) begin
          state_nxt = S_LEN_RD;
        end else if (at_last_el) begin
          state_nxt = S_HIT;
        end else begin
          state_nxt = S_EL_RD;
        end
      end
      S_HIT: begin
        state_nxt = S_IDLE;
      end
      S_NEW: begin
        state_nxt = no_room ? S_IDLE : S_COPY;
      end
      S_COPY: begin
        if (at_last_el) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    fill_nxt      = fill_r;
    over_nxt      = over_r;
    used_nxt      = used_r;
    e_nxt         = e_r;
    pos_nxt       = pos_r;
    i_nxt         = i_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    buf_we        = 1'b0;
    buf_waddr     = pos_r;
    buf_wdata     = v_r;
    cmd           = '0;
    ent_addr      = e_r[EW-1:0];
    el_idx        = i_r;
    wr_cnt        = cnt_inc;
    wr_el         = buf_r[i_r];
    unique case (state_r)
      S_IDLE: begin
        if (start_ok) begin
          if (in_data.action == ACT_CLEAR) begin
            used_nxt = '0;
            fill_nxt = '0;
            over_nxt = 1'b0;
          end else if (!at_full_len) begin
            v_nxt    = in_data.element_value;
            last_nxt = in_data.last_of_tuple;
            pos_nxt  = IW'(fill_r);
          end else if (in_data.last_of_tuple) begin
            // overlong tuple ends: dropped
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.distinct_total = 7'(used_r);
            out_data_nxt.tuple_too_long = 1'b1;
            fill_nxt = '0;
            over_nxt = 1'b0;
          end else begin
            over_nxt = 1'b1;
          end
        end
      end
      S_INSERT: begin
        // shift one larger element up, or drop the new one in its slot
        buf_we = 1'b1;
        if (shift_more) begin
          buf_wdata = prev_el;
          pos_nxt   = pos_dec;
        end else begin
          fill_nxt = FW'(fill_r + 1'b1);
          e_nxt    = '0;
          if (over_r && last_r) begin
            e_nxt = '0;
          end
        end
      end
      S_LEN_RD: begin
        cmd.ent_rd = !scan_done;
      end
      S_LEN_CMP: begin
        i_nxt = '0;
        if (rd_len != fill_r) begin
          e_nxt = UW'(e_r + 1'b1);
        end
      end
      S_EL_RD: begin
        cmd.el_rd = 1'b1;
      end
      S_EL_CMP: begin
        if (!el_equal) begin
          e_nxt = UW'(e_r + 1'b1);
        end else if (!at_last_el) begin
          i_nxt = IW'(i_r + 1'b1);
        end
      end
      S_HIT: begin
        // saturating count update of the matched entry
        cmd.ent_wr    = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.entry_index    = 6'(e_r);
        out_data_nxt.frequency      = 16'(cnt_inc);
        out_data_nxt.distinct_total = 7'(used_r);
        fill_nxt = '0;
        over_nxt = 1'b0;
      end
      S_NEW: begin
        i_nxt = '0;
        if (no_room) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.distinct_total = 7'(used_r);
          out_data_nxt.table_full     = 1'b1;
          fill_nxt = '0;
          over_nxt = 1'b0;
        end
      end
      S_COPY: begin
        // one element per cycle into the next free row
        ent_addr  = used_r[EW-1:0];
        cmd.el_wr = 1'b1;
        wr_cnt    = COUNT_BITS'(1);
        if (at_last_el) begin
          cmd.ent_wr    = 1'b1;
          used_nxt      = UW'(used_r + 1'b1);
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.entry_index    = 6'(used_r);
          out_data_nxt.frequency      = 16'(1);
          out_data_nxt.is_new         = 1'b1;
          out_data_nxt.distinct_total = 7'(UW'(used_r + 1'b1));
          fill_nxt = '0;
          over_nxt = 1'b0;
        end else begin
          i_nxt = IW'(i_r + 1'b1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      over_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      over_r      <= over_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    pos_r      <= pos_nxt;
    i_r        <= i_nxt;
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
    if (buf_we) begin
      buf_r[buf_waddr] <= buf_wdata;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/utfc_table.sv =====
// distinct tuple table: element, length and count memories with registered reads
// depends on utfc_pkg for the command struct
`default_nettype none

module utfc_table #(
  parameter int unsigned MAX_TUPLE_LEN = utfc_pkg::DEF_MAX_TUPLE_LEN,
  parameter int unsigned TABLE_DEPTH   = utfc_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned COUNT_BITS    = utfc_pkg::DEF_COUNT_BITS,
  localparam int unsigned FW = $clog2(MAX_TUPLE_LEN + 1),
  localparam int unsigned IW = (MAX_TUPLE_LEN > 1) ? $clog2(MAX_TUPLE_LEN) : 1,
  localparam int unsigned EW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire                   clk,
  input  utfc_pkg::tbl_cmd_t    cmd,
  input  wire [EW-1:0]          ent_addr,
  input  wire [IW-1:0]          el_idx,
  input  wire [FW-1:0]          wr_len,
  input  wire [COUNT_BITS-1:0]  wr_cnt,
  input  wire [31:0]            wr_el,
  output logic [FW-1:0]         rd_len,
  output logic [COUNT_BITS-1:0] rd_cnt,
  output logic [31:0]           rd_el
);
  import utfc_pkg::*;

  localparam int unsigned EL_DEPTH = TABLE_DEPTH << IW;

  logic [FW-1:0]         len_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];
  logic [31:0]           el_mem  [EL_DEPTH];

  logic [EW+IW-1:0] el_addr;
  assign el_addr = {ent_addr, el_idx};

  // per entry length and count, read data held until the next read
  always_ff @(posedge clk) begin
    if (cmd.ent_wr) begin
      len_mem[ent_addr] <= wr_len;
      cnt_mem[ent_addr] <= wr_cnt;
    end
    if (cmd.ent_rd) begin
      rd_len <= len_mem[ent_addr];
      rd_cnt <= cnt_mem[ent_addr];
    end
  end

  // sorted elements, one row of 2**IW slots (at least MAX_TUPLE_LEN) per entry
  always_ff @(posedge clk) begin
    if (cmd.el_wr) begin
      el_mem[el_addr] <= wr_el;
    end
    if (cmd.el_rd) begin
      rd_el <= el_mem[el_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utfc_checker.sv =====
// port-level checker for the unordered tuple frequency counter, with its bind
// depends on utfc_pkg for the transaction payload types
`default_nettype none

module utfc_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input utfc_pkg::out_item_t out_data
);
  import utfc_pkg::*;

  // a result is produced only by a busy cycle or an accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a preceding transaction");

  // a result is shown only once the block is ready again
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while still busy");

  // at most one outcome flag per result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.is_new, out_data.table_full,
                            out_data.tuple_too_long}))
    else $error("conflicting result flags");

  // dropped tuples carry no entry and no count
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.table_full || out_data.tuple_too_long)) |->
      (out_data.entry_index == '0 && out_data.frequency == '0))
    else $error("dropped tuple reports an entry");

  // a new entry starts at count one and is counted in the total
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_new) |->
      (out_data.frequency == 16'd1 && out_data.distinct_total != '0))
    else $error("bad new entry result");

endmodule

bind unordered_tuple_frequency_counter utfc_checker u_utfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/unordered_tuple_frequency_counter_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the unordered tuple frequency counter: directed table,
// random tuples, then a back-to-back repeat run; depends on utfc_pkg and the rtl top level

module unordered_tuple_frequency_counter_test;
  import utfc_pkg::*;

  localparam int MAX_LEN     = DEF_MAX_TUPLE_LEN;
  localparam int DEPTH       = DEF_TABLE_DEPTH;
  localparam int CNT_MAX     = (1 << DEF_COUNT_BITS) - 1;
  localparam int LONGEST     = MAX_LEN + 4;
  localparam int RAND_ITEMS  = 400;
  localparam int REPEATS     = 16;
  localparam int CYCLE_LIMIT = 8_000_000;

  // one stimulus row: the transaction plus an optional hand-written result
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  unordered_tuple_frequency_counter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // tuple collector and table of distinct tuples, as the block should hold them
  logic signed [31:0] tup_buf [MAX_LEN];
  int                 tup_fill = 0;
  bit                 tup_over = 1'b0;
  logic signed [31:0] ent_el [DEPTH][MAX_LEN];
  int                 ent_len [DEPTH];
  int                 ent_cnt [DEPTH];
  int                 ent_used = 0;

  // results still owed by the block, oldest first
  out_item_t tally_q [$];
  logic      exp_typed = 1'b0;
  out_item_t exp_res = '0;

  bit idle_on = 1'b1;
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int clears = 0;
  int checked = 0;
  int n_new = 0, n_hit = 0, n_full = 0, n_long = 0;

  // apply one transaction to the tuple state; returns 1 when it ends a tuple
  function automatic bit count_step(input in_item_t it, output out_item_t r);
    logic signed [31:0] v;
    int pos, e, k;
    bit hit;
    r = '0;
    if (it.action == ACT_CLEAR) begin
      ent_used = 0;
      tup_fill = 0;
      tup_over = 1'b0;
      return 1'b0;
    end
    // insertion sort on signed value, extra elements only mark the tuple overlong
    if (tup_fill < MAX_LEN) begin
      v   = it.element_value;
      pos = tup_fill;
      while (pos > 0 && tup_buf[pos-1] > v) begin
        tup_buf[pos] = tup_buf[pos-1];
        pos--;
      end
      tup_buf[pos] = v;
      tup_fill++;
    end else begin
      tup_over = 1'b1;
    end
    if (!it.last_of_tuple) return 1'b0;
    hit = 1'b0;
    if (tup_over) begin
      r.tuple_too_long = 1'b1;
    end else begin
      // first entry with equal length and equal sorted elements
      for (e = 0; e < ent_used && !hit; e++) begin
        if (ent_len[e] == tup_fill) begin
          hit = 1'b1;
          for (k = 0; k < tup_fill; k++)
            if (ent_el[e][k] != tup_buf[k]) hit = 1'b0;
          if (hit) begin
            if (ent_cnt[e] < CNT_MAX) ent_cnt[e]++;
            r.entry_index = 6'(e);
            r.frequency   = 16'(ent_cnt[e]);
          end
        end
      end
      if (!hit) begin
        if (ent_used < DEPTH) begin
          for (k = 0; k < tup_fill; k++) ent_el[ent_used][k] = tup_buf[k];
          ent_len[ent_used] = tup_fill;
          ent_cnt[ent_used] = 1;
          r.entry_index = 6'(ent_used);
          r.frequency   = 16'd1;
          r.is_new      = 1'b1;
          ent_used++;
        end else begin
          r.table_full = 1'b1;
        end
      end
    end
    tup_fill = 0;
    tup_over = 1'b0;
    r.distinct_total = 7'(ent_used);
    return 1'b1;
  endfunction

  function automatic dir_row_t plain_row(input logic act, input logic [31:0] v,
                                         input logic last);
    dir_row_t r;
    r = '0;
    r.item.action        = act;
    r.item.element_value = v;
    r.item.last_of_tuple = last;
    return r;
  endfunction

  // tuple end with its result written out by hand
  function automatic dir_row_t known_row(input logic [31:0] v, input int idx, input int freq,
                                         input bit fresh, input int total, input bit full,
                                         input bit ovl);
    dir_row_t r;
    r = plain_row(ACT_PUSH, v, 1'b1);
    r.typed              = 1'b1;
    r.res.entry_index    = 6'(idx);
    r.res.frequency      = 16'(freq);
    r.res.is_new         = fresh;
    r.res.distinct_total = 7'(total);
    r.res.table_full     = full;
    r.res.tuple_too_long = ovl;
    return r;
  endfunction

  function automatic void field_check(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // drive one transaction from a falling edge and hold it until taken
  task automatic send_row(input dir_row_t r);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    in_data   <= r.item;
    exp_typed = r.typed;
    exp_res   = r.res;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (r.item.action == ACT_CLEAR) clears++;
    @(negedge clk);
  endtask

  // result check first, then prediction for a transaction taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    if (rst_n) begin
      if (out_valid) begin
        if (tally_q.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with nothing expected", $time, out_data);
        end else begin
          want = tally_q.pop_front();
          checked++;
          field_check("entry_index", int'(want.entry_index), int'(out_data.entry_index));
          field_check("frequency", int'(want.frequency), int'(out_data.frequency));
          field_check("is_new", int'(want.is_new), int'(out_data.is_new));
          field_check("distinct_total", int'(want.distinct_total),
                      int'(out_data.distinct_total));
          field_check("table_full", int'(want.table_full), int'(out_data.table_full));
          field_check("tuple_too_long", int'(want.tuple_too_long),
                      int'(out_data.tuple_too_long));
          if (out_data.is_new) n_new++;
          else if (out_data.table_full) n_full++;
          else if (out_data.tuple_too_long) n_long++;
          else n_hit++;
        end
      end
      if (start && !busy) begin
        if (count_step(in_data, pred)) tally_q.push_back(exp_typed ? exp_res : pred);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run stalled, %0d cycles without finishing", $time, CYCLE_LIMIT);
      $display("unordered_tuple_frequency_counter_test: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows [$];
    logic [31:0] cand [LONGEST];
    logic [31:0] seen_el [DEPTH][MAX_LEN];
    int          seen_len [DEPTH];
    int          seen_n, cand_len, pick, k, j, mode;
    bit          replay;
    logic [31:0] t;

    seen_n = 0;

    // directed: permutations, extremes, length mismatch, overlong, clear mid-tuple
    rows.push_back(known_row(32'd5, 0, 1, 1, 1, 0, 0));
    rows.push_back(plain_row(ACT_PUSH, 32'hffff_ffff, 1'b0));
    rows.push_back(known_row(32'd7, 1, 1, 1, 2, 0, 0));
    rows.push_back(plain_row(ACT_PUSH, 32'd7, 1'b0));
    rows.push_back(known_row(32'hffff_ffff, 1, 2, 0, 2, 0, 0));
    rows.push_back(plain_row(ACT_PUSH, 32'h8000_0000, 1'b0));
    rows.push_back(known_row(32'h7fff_ffff, 2, 1, 1, 3, 0, 0));
    rows.push_back(plain_row(ACT_PUSH, 32'h7fff_ffff, 1'b0));
    rows.push_back(known_row(32'h8000_0000, 2, 2, 0, 3, 0, 0));
    rows.push_back(plain_row(ACT_PUSH, 32'd5, 1'b0));
    rows.push_back(known_row(32'd5, 3, 1, 1, 4, 0, 0));
    rows.push_back(known_row(32'd5, 0, 2, 0, 4, 0, 0));
    for (k = 0; k < MAX_LEN; k++)
      rows.push_back(plain_row(ACT_PUSH, 32'(k * 3 - 7), 1'b0));
    rows.push_back(known_row(32'd9, 0, 0, 0, 4, 0, 1));
    rows.push_back(plain_row(ACT_PUSH, 32'd3, 1'b0));
    rows.push_back(plain_row(ACT_CLEAR, 32'h5a5a_a5a5, 1'b1));
    rows.push_back(known_row(32'd5, 0, 1, 1, 1, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_row(rows[i]);

    // random tuples: replays in shuffled order, near misses, fresh and overlong ones
    while (items_sent < rows.size() + RAND_ITEMS) begin
      if (ent_used == DEPTH && $urandom_range(0, 5) == 0)
        send_row(plain_row(ACT_CLEAR, $urandom, 1'($urandom)));
      mode   = $urandom_range(0, 99);
      replay = 1'b0;
      if (seen_n > 0 && mode < 45) begin
        pick     = $urandom_range(0, seen_n - 1);
        cand_len = seen_len[pick];
        for (k = 0; k < cand_len; k++) cand[k] = seen_el[pick][k];
        for (k = cand_len - 1; k > 0; k--) begin
          j       = $urandom_range(0, k);
          t       = cand[k];
          cand[k] = cand[j];
          cand[j] = t;
        end
        replay = (mode < 35);
        // near miss: one bit off, one element more, or one less
        if (!replay) begin
          case ($urandom_range(0, 2))
            0: cand[$urandom_range(0, cand_len - 1)] ^= 32'(1) << $urandom_range(0, 31);
            1: if (cand_len < MAX_LEN) begin
              cand[cand_len] = cand[0];
              cand_len++;
            end
            default: if (cand_len > 1) cand_len--;
          endcase
        end
      end else if (mode >= 45 && mode < 52) begin
        cand_len = $urandom_range(MAX_LEN + 1, LONGEST);
        for (k = 0; k < cand_len; k++) cand[k] = $urandom;
      end else begin
        cand_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN) :
                                                 $urandom_range(1, 2);
        for (k = 0; k < cand_len; k++) begin
          case ($urandom_range(0, 3))
            0: cand[k] = $urandom;
            1: cand[k] = 32'($urandom_range(0, 6)) - 32'd3;
            2: cand[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: cand[k] = (k > 0) ? cand[k-1] : 32'd0;
          endcase
        end
      end
      // keep new shapes around for later repeats
      if (!replay && cand_len <= MAX_LEN) begin
        pick = (seen_n < DEPTH) ? seen_n : $urandom_range(0, DEPTH - 1);
        for (k = 0; k < cand_len; k++) seen_el[pick][k] = cand[k];
        seen_len[pick] = cand_len;
        if (seen_n < DEPTH) seen_n++;
      end
      for (k = 0; k < cand_len; k++) begin
        // rare clear that breaks the tuple being collected
        if ($urandom_range(0, 399) == 0)
          send_row(plain_row(ACT_CLEAR, $urandom, 1'($urandom)));
        send_row(plain_row(ACT_PUSH, cand[k], k == cand_len - 1));
      end
    end

    // back to back, one tuple repeated on a fresh table
    idle_on = 1'b0;
    send_row(plain_row(ACT_CLEAR, 32'd0, 1'b0));
    t = $urandom;
    for (k = 0; k < REPEATS; k++) send_row(plain_row(ACT_PUSH, t, 1'b1));
    send_row(known_row(t, 0, REPEATS + 1, 0, 1, 0, 0));
    start <= 1'b0;

    while (tally_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("sent %0d transactions (%0d clears), checked %0d results", items_sent, clears,
             checked);
    $display("results: %0d new entries, %0d repeats, %0d table-full drops, %0d overlong drops",
             n_new, n_hit, n_full, n_long);
    if (errors == 0) begin
      $display("unordered_tuple_frequency_counter_test: clean");
    end else begin
      $display("unordered_tuple_frequency_counter_test: errors");
    end
    $finish;
  end

endmodule
